>>> hw/rtl/ggc_pkg.sv
`timescale 1ns / 1ps

package ggc_pkg;

    localparam int VERT_W  = 6;
    localparam int COLOR_W = 6;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic              set;
        logic              clr;
        logic [VERT_W-1:0] row;
        logic [VERT_W-1:0] col;
    } adj_cmd_t;

    typedef struct packed {
        logic               we;
        logic [VERT_W-1:0]  waddr;
        logic [COLOR_W-1:0] wdata;
        logic [VERT_W-1:0]  raddr;
    } color_cmd_t;

endpackage

>>> hw/rtl/greedy_graph_coloring_top.sv
`timescale 1ns / 1ps

// Greedy graph coloring. An edge item (kind 0) sets both symmetric bits of the adjacency
// matrix, writing them one after the other since the matrix has one write port; an edge
// with an endpoint above MAX_VERTICES is dropped. A run item (kind 1) colors vertices 1 to
// the highest vertex seen and returns one item per vertex, the last one flagged with the
// color count; a run with no vertex above 0 seen returns nothing. Each vertex costs one
// adjacency row read, a neighbor scan of one neighbor per cycle, a pick of color 1 when no
// neighbor is colored or else of the first free candidate color tried from 2 upward, and
// an emit that waits out any output stall. After every run, and after reset, a clearing
// sweep over rows 0 to MAX_VERTICES wipes the matrix and the colors; no item is accepted meanwhile.
module greedy_graph_coloring_top #(
    parameter int MAX_VERTICES = 63
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [ggc_pkg::VERT_W-1:0]  s_vertex_a,
    input  logic [ggc_pkg::VERT_W-1:0]  s_vertex_b,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ggc_pkg::VERT_W-1:0]  m_vertex,
    output logic [ggc_pkg::COLOR_W-1:0] m_color,
    output logic                        m_last,
    output logic [ggc_pkg::COLOR_W-1:0] m_color_count
);
    import ggc_pkg::*;

    localparam int DEPTH = MAX_VERTICES + 1;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_EDGE  = 8'b0000_0100,
        S_ROW   = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_PICK  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [VERT_W-1:0]  max_reg, max_next;
    logic [VERT_W-1:0]  edge_a_reg, edge_a_next;
    logic [VERT_W-1:0]  edge_b_reg, edge_b_next;
    logic [VERT_W-1:0]  v_reg, v_next;
    logic [VERT_W-1:0]  n_reg, n_next;
    logic [COLOR_W-1:0] cand_reg, cand_next;
    logic [COLOR_W-1:0] chosen_reg, chosen_next;
    logic [COLOR_W-1:0] top_reg, top_next;
    logic [DEPTH-1:0]   used_reg, used_next;
    logic               any_reg, any_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               chk_adj_reg, chk_adj_next;

    logic               m_valid_reg, m_valid_next;
    logic [VERT_W-1:0]  m_vertex_reg, m_vertex_next;
    logic [COLOR_W-1:0] m_color_reg, m_color_next;
    logic               m_last_reg, m_last_next;
    logic [COLOR_W-1:0] m_count_reg, m_count_next;

    adj_cmd_t           adj_cmd;
    color_cmd_t         color_cmd;
    logic [DEPTH-1:0]   adj_row;
    logic [COLOR_W-1:0] color_q;
    logic               accept;
    logic               edge_ok;
    logic               is_last;
    logic [COLOR_W-1:0] new_top;

    ggc_adj_ram #(.DEPTH(DEPTH)) u_adj (
        .aclk    (aclk),
        .cmd     (adj_cmd),
        .rd_row  (v_reg),
        .rd_data (adj_row)
    );

    ggc_color_ram #(.DEPTH(DEPTH)) u_color (
        .aclk    (aclk),
        .cmd     (color_cmd),
        .rd_data (color_q)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign edge_ok = (s_vertex_a <= VERT_W'(MAX_VERTICES)) &&
                     (s_vertex_b <= VERT_W'(MAX_VERTICES));
    assign is_last = (v_reg == max_reg);
    assign new_top = (chosen_reg > top_reg) ? chosen_reg : top_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        max_next       = max_reg;
        edge_a_next    = edge_a_reg;
        edge_b_next    = edge_b_reg;
        v_next         = v_reg;
        n_next         = n_reg;
        cand_next      = cand_reg;
        chosen_next    = chosen_reg;
        top_next       = top_reg;
        used_next      = used_reg;
        any_next       = any_reg;
        chk_valid_next = 1'b0;
        chk_adj_next   = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_vertex_next  = m_vertex_reg;
        m_color_next   = m_color_reg;
        m_last_next    = m_last_reg;
        m_count_next   = m_count_reg;

        adj_cmd         = '0;
        color_cmd       = '0;
        color_cmd.raddr = n_reg;

        if (chk_valid_reg && chk_adj_reg && (color_q != '0)) begin
            used_next[color_q[AW-1:0]] = 1'b1;
            any_next                   = 1'b1;
        end

        unique case (state_reg)
            S_CLEAR: begin
                adj_cmd.clr     = 1'b1;
                adj_cmd.row     = VERT_W'(clr_reg);
                color_cmd.we    = 1'b1;
                color_cmd.waddr = VERT_W'(clr_reg);
                color_cmd.wdata = '0;
                clr_next        = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_VERTICES)) begin
                    clr_next   = '0;
                    max_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_EDGE) begin
                        if (edge_ok) begin
                            adj_cmd.set = 1'b1;
                            adj_cmd.row = s_vertex_a;
                            adj_cmd.col = s_vertex_b;
                            edge_a_next = s_vertex_a;
                            edge_b_next = s_vertex_b;
                            if ((s_vertex_a >= s_vertex_b) && (s_vertex_a > max_reg)) begin
                                max_next = s_vertex_a;
                            end else if (s_vertex_b > max_reg) begin
                                max_next = s_vertex_b;
                            end
                            state_next = S_EDGE;
                        end
                    end else begin
                        top_next = '0;
                        v_next   = VERT_W'(1);
                        used_next = '0;
                        any_next  = 1'b0;
                        if (max_reg == '0) begin
                            state_next = S_CLEAR;
                        end else begin
                            state_next = S_ROW;
                        end
                    end
                end
            end
            S_EDGE: begin
                adj_cmd.set = 1'b1;
                adj_cmd.row = edge_b_reg;
                adj_cmd.col = edge_a_reg;
                state_next  = S_IDLE;
            end
            S_ROW: begin
                n_next     = VERT_W'(1);
                state_next = S_SCAN;
            end
            S_SCAN: begin
                chk_valid_next = 1'b1;
                chk_adj_next   = adj_row[n_reg[AW-1:0]];
                n_next         = n_reg + VERT_W'(1);
                if (n_reg == max_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                cand_next  = COLOR_W'(2);
                state_next = S_PICK;
            end
            S_PICK: begin
                if (!any_reg) begin
                    chosen_next = COLOR_W'(1);
                    state_next  = S_EMIT;
                end else if (!used_reg[cand_reg[AW-1:0]]) begin
                    chosen_next = cand_reg;
                    state_next  = S_EMIT;
                end else begin
                    cand_next = cand_reg + COLOR_W'(1);
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    color_cmd.we    = 1'b1;
                    color_cmd.waddr = v_reg;
                    color_cmd.wdata = chosen_reg;
                    top_next        = new_top;
                    m_valid_next    = 1'b1;
                    m_vertex_next   = v_reg;
                    m_color_next    = chosen_reg;
                    m_last_next     = is_last;
                    m_count_next    = is_last ? new_top : '0;
                    used_next       = '0;
                    any_next        = 1'b0;
                    if (is_last) begin
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end else begin
                        v_next     = v_reg + VERT_W'(1);
                        state_next = S_ROW;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            max_reg       <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            max_reg       <= max_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        edge_a_reg   <= edge_a_next;
        edge_b_reg   <= edge_b_next;
        v_reg        <= v_next;
        n_reg        <= n_next;
        cand_reg     <= cand_next;
        chosen_reg   <= chosen_next;
        top_reg      <= top_next;
        used_reg     <= used_next;
        any_reg      <= any_next;
        chk_adj_reg  <= chk_adj_next;
        m_vertex_reg <= m_vertex_next;
        m_color_reg  <= m_color_next;
        m_last_reg   <= m_last_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_vertex      = m_vertex_reg;
    assign m_color       = m_color_reg;
    assign m_last        = m_last_reg;
    assign m_color_count = m_count_reg;

endmodule

>>> hw/rtl/ggc_adj_ram.sv
`timescale 1ns / 1ps

module ggc_adj_ram #(
    parameter int DEPTH = 64
) (
    input  logic                      aclk,
    input  ggc_pkg::adj_cmd_t         cmd,
    input  logic [ggc_pkg::VERT_W-1:0] rd_row,
    output logic [DEPTH-1:0]          rd_data
);
    import ggc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [DEPTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mem[cmd.row[AW-1:0]] <= '0;
        end else if (cmd.set) begin
            mem[cmd.row[AW-1:0]][cmd.col[AW-1:0]] <= 1'b1;
        end
        rd_data_reg <= mem[rd_row[AW-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ggc_color_ram.sv
`timescale 1ns / 1ps

module ggc_color_ram #(
    parameter int DEPTH = 64
) (
    input  logic                        aclk,
    input  ggc_pkg::color_cmd_t         cmd,
    output logic [ggc_pkg::COLOR_W-1:0] rd_data
);
    import ggc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem[cmd.waddr[AW-1:0]] <= cmd.wdata;
        end
        rd_data_reg <= mem[cmd.raddr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> test/tb_greedy_graph_coloring_top.sv
`timescale 1ns / 1ps

module tb_greedy_graph_coloring_top;
    import ggc_pkg::*;

    localparam int MAX_V         = 63;
    localparam int TOTAL_ITEMS   = 310;
    localparam int STALL_AT      = 120;
    localparam int STALL_CYCLES  = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int WATCHDOG      = 5000;
    localparam int N_DIRECTED    = 22;
    localparam int N_TYPED       = 17;

    typedef struct packed {
        logic [VERT_W-1:0]  vertex;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic [COLOR_W-1:0] color_count;
    } coloring_t;

    typedef struct packed {
        logic              kind;
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
        logic              typed;
        logic [6:0]        n_typed;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_kind;
    logic [VERT_W-1:0]   s_vertex_a;
    logic [VERT_W-1:0]   s_vertex_b;
    logic                m_valid;
    logic                m_ready;
    logic [VERT_W-1:0]   m_vertex;
    logic [COLOR_W-1:0]  m_color;
    logic                m_last;
    logic [COLOR_W-1:0]  m_color_count;

    logic [MAX_V:0]      graph_rows [0:MAX_V];
    logic [COLOR_W-1:0]  vertex_color [0:MAX_V];
    int                  top_vertex;
    coloring_t           fresh_colorings [$];
    coloring_t           pending_colorings [$];

    int errors = 0;
    int items_sent = 0;
    int send_calm = 0;
    int recv_calm = 0;
    int idle_cycles = 0;

    stim_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{KIND_RUN,  6'd0,  6'd0,  1'b1, 7'd0},
        '{KIND_EDGE, 6'd1,  6'd2,  1'b0, 7'd0},
        '{KIND_RUN,  6'd0,  6'd0,  1'b1, 7'd2},
        '{KIND_EDGE, 6'd0,  6'd0,  1'b0, 7'd0},
        '{KIND_RUN,  6'd63, 6'd63, 1'b1, 7'd0},
        '{KIND_EDGE, 6'd0,  6'd5,  1'b0, 7'd0},
        '{KIND_RUN,  6'd0,  6'd0,  1'b1, 7'd5},
        '{KIND_EDGE, 6'd3,  6'd3,  1'b0, 7'd0},
        '{KIND_RUN,  6'd0,  6'd0,  1'b1, 7'd3},
        '{KIND_EDGE, 6'd63, 6'd63, 1'b0, 7'd0},
        '{KIND_EDGE, 6'd63, 6'd1,  1'b0, 7'd0},
        '{KIND_RUN,  6'd0,  6'd0,  1'b0, 7'd0},
        '{KIND_EDGE, 6'd1,  6'd2,  1'b0, 7'd0},
        '{KIND_EDGE, 6'd2,  6'd3,  1'b0, 7'd0},
        '{KIND_EDGE, 6'd3,  6'd1,  1'b0, 7'd0},
        '{KIND_RUN,  6'd0,  6'd0,  1'b1, 7'd3},
        '{KIND_EDGE, 6'd2,  6'd3,  1'b0, 7'd0},
        '{KIND_EDGE, 6'd4,  6'd3,  1'b0, 7'd0},
        '{KIND_RUN,  6'd0,  6'd0,  1'b1, 7'd4},
        '{KIND_EDGE, 6'd42, 6'd21, 1'b0, 7'd0},
        '{KIND_EDGE, 6'd21, 6'd42, 1'b0, 7'd0},
        '{KIND_RUN,  6'd0,  6'd0,  1'b0, 7'd0}
    };

    coloring_t typed_colorings [0:N_TYPED-1] = '{
        '{6'd1, 6'd1, 1'b0, 6'd0},
        '{6'd2, 6'd2, 1'b1, 6'd2},
        '{6'd1, 6'd1, 1'b0, 6'd0},
        '{6'd2, 6'd1, 1'b0, 6'd0},
        '{6'd3, 6'd1, 1'b0, 6'd0},
        '{6'd4, 6'd1, 1'b0, 6'd0},
        '{6'd5, 6'd1, 1'b1, 6'd1},
        '{6'd1, 6'd1, 1'b0, 6'd0},
        '{6'd2, 6'd1, 1'b0, 6'd0},
        '{6'd3, 6'd1, 1'b1, 6'd1},
        '{6'd1, 6'd1, 1'b0, 6'd0},
        '{6'd2, 6'd2, 1'b0, 6'd0},
        '{6'd3, 6'd3, 1'b1, 6'd3},
        '{6'd1, 6'd1, 1'b0, 6'd0},
        '{6'd2, 6'd1, 1'b0, 6'd0},
        '{6'd3, 6'd2, 1'b0, 6'd0},
        '{6'd4, 6'd3, 1'b1, 6'd3}
    };

    greedy_graph_coloring_top #(
        .MAX_VERTICES (MAX_V)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_vertex_a    (s_vertex_a),
        .s_vertex_b    (s_vertex_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex      (m_vertex),
        .m_color       (m_color),
        .m_last        (m_last),
        .m_color_count (m_color_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_graph();
        for (int i = 0; i <= MAX_V; i++) begin
            graph_rows[i]   = '0;
            vertex_color[i] = '0;
        end
        top_vertex = 0;
    endfunction

    function automatic void predict_coloring(logic kind, logic [VERT_W-1:0] a,
                                             logic [VERT_W-1:0] b);
        int  highest;
        int  chosen;
        bit  colored;
        bit  clash;
        fresh_colorings.delete();
        if (kind == KIND_EDGE) begin
            if (int'(a) > MAX_V || int'(b) > MAX_V) begin
                return;
            end
            graph_rows[a][b] = 1'b1;
            graph_rows[b][a] = 1'b1;
            if (int'(a) > top_vertex) top_vertex = int'(a);
            if (int'(b) > top_vertex) top_vertex = int'(b);
            return;
        end
        highest = 0;
        for (int v = 1; v <= top_vertex; v++) begin
            colored = 1'b0;
            for (int n = 1; n <= top_vertex; n++) begin
                if (graph_rows[v][n] && vertex_color[n] != 0) colored = 1'b1;
            end
            chosen = 1;
            if (colored) begin
                chosen = highest + 1;
                for (int c = 2; c <= highest + 1; c++) begin
                    clash = 1'b0;
                    for (int n = 1; n <= top_vertex; n++) begin
                        if (graph_rows[v][n] && int'(vertex_color[n]) == c) clash = 1'b1;
                    end
                    if (!clash) begin
                        chosen = c;
                        break;
                    end
                end
            end
            chosen = chosen & 63;
            vertex_color[v] = COLOR_W'(chosen);
            if (chosen > highest) highest = chosen;
        end
        for (int v = 1; v <= top_vertex; v++) begin
            fresh_colorings.push_back('{VERT_W'(v), vertex_color[v], v == top_vertex,
                                        (v == top_vertex) ? COLOR_W'(highest) : '0});
        end
        clear_graph();
    endfunction

    task automatic send_item(logic kind, logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                             logic typed, int n_typed, inout int typed_idx);
        int gap;
        @(negedge aclk);
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 9) == 0) send_calm = $urandom_range(10, 30);
            gap = $urandom_range(0, 19);
        end
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_kind     = kind;
        s_vertex_a = a;
        s_vertex_b = b;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_coloring(kind, a, b);
        if (typed) begin
            for (int k = 0; k < n_typed; k++) begin
                pending_colorings.push_back(typed_colorings[typed_idx]);
                typed_idx++;
            end
        end else begin
            foreach (fresh_colorings[k]) pending_colorings.push_back(fresh_colorings[k]);
        end
    endtask

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        coloring_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_colorings.size() == 0) begin
                $error("unexpected item: vertex %0d color %0d", m_vertex, m_color);
                errors++;
            end else begin
                want = pending_colorings.pop_front();
                check_field("vertex", want.vertex, m_vertex);
                check_field("color", want.color, m_color);
                check_field("last", want.last, m_last);
                check_field("color_count", want.color_count, m_color_count);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int wait_cycles;
        int taken;
        taken   = 0;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            @(negedge aclk);
            if (taken == STALL_AT) begin
                m_ready = 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
            end
            if (recv_calm > 0) begin
                recv_calm--;
                wait_cycles = 0;
            end else begin
                if ($urandom_range(0, 9) == 0) recv_calm = $urandom_range(10, 30);
                wait_cycles = $urandom_range(0, 19);
            end
            if (wait_cycles > 0) begin
                m_ready = 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    initial begin
        int typed_idx;
        int pick;
        int size;
        int edges;
        typed_idx  = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = KIND_EDGE;
        s_vertex_a = '0;
        s_vertex_b = '0;
        clear_graph();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].kind, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].typed, int'(directed_rows[i].n_typed), typed_idx);
        end

        // Mostly whole graphs followed by a run, with stray items and bare runs mixed in.
        while (items_sent < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                send_item(logic'($urandom_range(0, 1)), VERT_W'($urandom_range(0, 63)),
                          VERT_W'($urandom_range(0, 63)), 1'b0, 0, typed_idx);
            end else if (pick == 2) begin
                send_item(KIND_RUN, VERT_W'($urandom_range(0, 63)),
                          VERT_W'($urandom_range(0, 63)), 1'b0, 0, typed_idx);
            end else begin
                size  = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 63)
                                                     : $urandom_range(2, 12);
                edges = $urandom_range(1, (size * 3 > 25) ? 25 : size * 3);
                repeat (edges) begin
                    send_item(KIND_EDGE, VERT_W'($urandom_range(0, size)),
                              VERT_W'($urandom_range(0, size)), 1'b0, 0, typed_idx);
                end
                send_item(KIND_RUN, VERT_W'($urandom_range(0, 63)),
                          VERT_W'($urandom_range(0, 63)), 1'b0, 0, typed_idx);
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_colorings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
